@@ design/weathervane_yaw_rate_macros.svh @@
// Assertion macros shared by the weathervane yaw-rate checker
`ifndef WEATHERVANE_YAW_RATE_MACROS_SVH
`define WEATHERVANE_YAW_RATE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WYR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define WYR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wyr_pkg.sv @@
// Types, register codes and constants of the weathervane yaw-rate block
`default_nettype none
package wyr_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_ROLL_DEADBAND  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN           = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_YAW_RATE_LIMIT = 2'd2;

	localparam logic [14:0] ROLL_DEADBAND_RST  = 15'd182;
	localparam logic [15:0] GAIN_RST           = 16'd256;
	localparam logic [14:0] YAW_RATE_LIMIT_RST = 15'd6434;

	localparam int INV_GAIN_Q30 = 652032874;
	localparam logic [30:0] PI_Q29 = 31'd1686629713;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] heading;
	} in_beat_t;

	typedef struct packed {
		logic signed [15:0] yaw_rate;
		logic signed [15:0] roll_angle;
	} out_beat_t;

	// atan(2^-i) in 2^32-per-turn units
	function automatic logic [31:0] atan_turn32(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'h20000000;
			1: r = 32'h12E4051E;
			2: r = 32'h09FB385B;
			3: r = 32'h051111D4;
			4: r = 32'h028B0D43;
			5: r = 32'h0145D7E1;
			6: r = 32'h00A2F61E;
			7: r = 32'h00517C55;
			8: r = 32'h0028BE53;
			9: r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/wyr_cordic_cell.sv @@
// One CORDIC micro-rotation cell, rotation or vectoring mode
`default_nettype none
module wyr_cordic_cell #(
	parameter int XW = 33,
	parameter int ZW = 18,
	parameter int SW = 1,
	parameter int SHIFT = 0,
	parameter int STEP = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [XW-1:0] in_x,
	input  logic signed [XW-1:0] in_y,
	input  logic signed [ZW-1:0] in_z,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic signed [XW-1:0] out_x,
	output logic signed [XW-1:0] out_y,
	output logic signed [ZW-1:0] out_z,
	output logic [SW-1:0]        out_side
);
	localparam logic signed [ZW-1:0] STEP_Z = ZW'(STEP);

	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic ccw;

	assign xs = in_x >>> SHIFT;
	assign ys = in_y >>> SHIFT;
	assign ccw = VECTOR ? in_y[XW-1] : !in_z[ZW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				out_x <= in_x - ys;
				out_y <= in_y + xs;
				out_z <= in_z - STEP_Z;
			end else begin
				out_x <= in_x + ys;
				out_y <= in_y - xs;
				out_z <= in_z + STEP_Z;
			end
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

@@ design/wyr_isqrt_cell.sv @@
// One digit step of the bit-pair integer square root
`default_nettype none
module wyr_isqrt_cell #(
	parameter int VW = 63,
	parameter int K = 0,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [VW-1:0] in_v,
	input  logic [VW-1:0] in_res,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [VW-1:0] out_v,
	output logic [VW-1:0] out_res,
	output logic [SW-1:0] out_side
);
	localparam logic [VW-1:0] BIT = VW'(1) << (2 * K);

	logic [VW:0] trial;
	logic ge;

	assign trial = {1'b0, in_res} + {1'b0, BIT};
	assign ge = {1'b0, in_v} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ge) begin
				out_v   <= in_v - trial[VW-1:0];
				out_res <= (in_res >> 1) + BIT;
			end else begin
				out_v   <= in_v;
				out_res <= in_res >> 1;
			end
			out_side <= in_side;
		end
	end
endmodule
`default_nettype wire

@@ design/weathervane_yaw_rate.sv @@
// Weathervane yaw-rate demand: top level with the cell chains and arithmetic stages
//
// Input channel in_valid/in_stall/in_data carries one attitude setpoint quaternion
// and the heading per beat; output channel out_valid/out_stall/out_data returns one
// yaw-rate demand and roll angle per input beat, in order.
// Configuration: write cfg_data to register cfg_index while cfg_we is high, only when
// the pipeline is empty. Index 0 roll deadband, 1 gain, 2 yaw-rate limit.
// The pipeline is two product stages, the sine/cosine cell row, six rotate and square
// stages, 32 square-root cells, the arctangent cell row, four deadband and gain stages
// and the output register.
// Throughput is one beat per cycle while no valid result is stalled; every stage and cell advances together.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle; bubbles do not compress.
// Reset empties the pipeline and loads the register defaults.
`default_nettype none
module weathervane_yaw_rate #(
	parameter int ANGLE_WIDTH = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wyr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [wyr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  wyr_pkg::in_beat_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output wyr_pkg::out_beat_t                  out_data
);
	localparam int AW = ANGLE_WIDTH;
	localparam int N = CORDIC_STAGES;
	localparam int ZW = AW + 2;
	localparam int RXW = 33;
	localparam int VXW = 36;
	localparam int PW = 34;
	localparam int PZW = 33;
	localparam int RSW = 2 * PW + PZW;
	localparam int QW = 63;
	localparam int PYW = 34;
	localparam int SH_TAB = 32 - AW;
	localparam logic signed [ZW-1:0] QTR_Z = ZW'(1) <<< (AW - 2);
	localparam logic signed [RXW-1:0] INV_X = RXW'(wyr_pkg::INV_GAIN_Q30);

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int s);
		logic signed [63:0] half;
		logic signed [63:0] r;
		half = 64'sd1 <<< (s - 1);
		if (s == 0) begin
			r = v;
		end else if (v >= 0) begin
			r = (v + half) >>> s;
		end else begin
			r = -((-v + half) >>> s);
		end
		return r;
	endfunction

	logic en;
	logic [14:0] deadband_q;
	logic [15:0] gain_q;
	logic [14:0] limit_q;

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= wyr_pkg::ROLL_DEADBAND_RST;
			gain_q     <= wyr_pkg::GAIN_RST;
			limit_q    <= wyr_pkg::YAW_RATE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				wyr_pkg::REG_ROLL_DEADBAND: deadband_q <= cfg_data[14:0];
				wyr_pkg::REG_GAIN: gain_q <= cfg_data;
				wyr_pkg::REG_YAW_RATE_LIMIT: limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// stage 1: quaternion products, heading to internal angle
	logic signed [AW-1:0] a_c;
	generate
		if (AW >= 16) begin : g_aup
			assign a_c = AW'(in_data.heading) <<< (AW - 16);
		end else begin : g_adn
			logic signed [63:0] ar;
			assign ar = rnd(64'(in_data.heading), 16 - AW);
			assign a_c = ar[AW-1:0];
		end
	endgenerate

	logic valid_s1;
	logic signed [31:0] xz_s1, wy_s1, yz_s1, wx_s1, ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [AW-1:0] a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xz_s1 <= 32'(in_data.quat_x) * 32'(in_data.quat_z);
			wy_s1 <= 32'(in_data.quat_w) * 32'(in_data.quat_y);
			yz_s1 <= 32'(in_data.quat_y) * 32'(in_data.quat_z);
			wx_s1 <= 32'(in_data.quat_w) * 32'(in_data.quat_x);
			ww_s1 <= 32'(in_data.quat_w) * 32'(in_data.quat_w);
			xx_s1 <= 32'(in_data.quat_x) * 32'(in_data.quat_x);
			yy_s1 <= 32'(in_data.quat_y) * 32'(in_data.quat_y);
			zz_s1 <= 32'(in_data.quat_z) * 32'(in_data.quat_z);
			a_s1  <= a_c;
		end
	end

	// stage 2: body z axis, quadrant pre-rotation
	logic signed [ZW-1:0] a_ext;
	logic valid_s2;
	logic signed [PW-1:0] vx_s2, vy_s2;
	logic signed [PZW-1:0] vz_s2;
	logic signed [RXW-1:0] rx_s2, ry_s2;
	logic signed [ZW-1:0] rz_s2;

	assign a_ext = ZW'(a_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s2 <= (PW'(xz_s1) + PW'(wy_s1)) <<< 1;
			vy_s2 <= (PW'(yz_s1) - PW'(wx_s1)) <<< 1;
			vz_s2 <= PZW'(ww_s1) + PZW'(zz_s1) - PZW'(xx_s1) - PZW'(yy_s1);
			if (a_ext > QTR_Z) begin
				rx_s2 <= '0;
				ry_s2 <= INV_X;
				rz_s2 <= a_ext - QTR_Z;
			end else if (a_ext < -QTR_Z) begin
				rx_s2 <= '0;
				ry_s2 <= -INV_X;
				rz_s2 <= a_ext + QTR_Z;
			end else begin
				rx_s2 <= INV_X;
				ry_s2 <= '0;
				rz_s2 <= a_ext;
			end
		end
	end

	// sine/cosine cell row
	logic rv [0:N];
	logic signed [RXW-1:0] rx [0:N];
	logic signed [RXW-1:0] ry [0:N];
	logic signed [ZW-1:0] rz [0:N];
	logic [RSW-1:0] rside [0:N];

	assign rv[0] = valid_s2;
	assign rx[0] = rx_s2;
	assign ry[0] = ry_s2;
	assign rz[0] = rz_s2;
	assign rside[0] = {vx_s2, vy_s2, vz_s2};

	generate
		for (genvar i = 0; i < N; i++) begin : g_rot
			localparam logic [32:0] T = {1'b0, wyr_pkg::atan_turn32(i)} + (33'd1 << (SH_TAB - 1));
			localparam int STEP = int'(T >> SH_TAB);
			wyr_cordic_cell #(
				.XW(RXW), .ZW(ZW), .SW(RSW), .SHIFT(i), .STEP(STEP), .VECTOR(1'b0)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_valid(rv[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]),
				.in_side(rside[i]),
				.out_valid(rv[i+1]), .out_x(rx[i+1]), .out_y(ry[i+1]), .out_z(rz[i+1]),
				.out_side(rside[i+1])
			);
		end
	endgenerate

	// stage 3: round sine and cosine to Q24
	logic signed [63:0] c_c, s_c;
	logic valid_s3;
	logic signed [27:0] c_s3, s_s3;
	logic signed [PW-1:0] vx_s3, vy_s3;
	logic signed [PZW-1:0] vz_s3;

	assign c_c = rnd(64'(rx[N]), 6);
	assign s_c = rnd(64'(ry[N]), 6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= rv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s3 <= c_c[27:0];
			s_s3 <= s_c[27:0];
			{vx_s3, vy_s3, vz_s3} <= rside[N];
		end
	end

	// stage 4: rotation products
	logic valid_s4;
	logic signed [61:0] xc_s4, ys_s4, yc_s4, xs_s4;
	logic signed [PZW-1:0] vz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s4 <= 62'(vx_s3) * 62'(c_s3);
			ys_s4 <= 62'(vy_s3) * 62'(s_s3);
			yc_s4 <= 62'(vy_s3) * 62'(c_s3);
			xs_s4 <= 62'(vx_s3) * 62'(s_s3);
			vz_s4 <= vz_s3;
		end
	end

	// stage 5: rotated vector back in Q28
	logic signed [63:0] nx_c, ny_c;
	logic valid_s5;
	logic signed [35:0] nx_s5, ny_s5;
	logic signed [PZW-1:0] vz_s5;

	assign nx_c = rnd(64'(xc_s4) + 64'(ys_s4), 24);
	assign ny_c = rnd(64'(yc_s4) - 64'(xs_s4), 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s5 <= nx_c[35:0];
			ny_s5 <= ny_c[35:0];
			vz_s5 <= vz_s4;
		end
	end

	// stage 6: scale to Q26
	logic signed [63:0] px_c, py_c, pz_c;
	logic valid_s6;
	logic signed [PYW-1:0] px_s6, py_s6;
	logic signed [30:0] pz_s6;

	assign px_c = rnd(64'(nx_s5), 2);
	assign py_c = rnd(64'(ny_s5), 2);
	assign pz_c = rnd(64'(vz_s5), 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s6 <= px_c[PYW-1:0];
			py_s6 <= py_c[PYW-1:0];
			pz_s6 <= pz_c[30:0];
		end
	end

	// stage 7: squares
	logic signed [61:0] sqx_c;
	logic signed [59:0] sqz_c;
	logic valid_s7;
	logic [60:0] sqx_s7;
	logic [58:0] sqz_s7;
	logic signed [PYW-1:0] py_s7;

	assign sqx_c = 62'(px_s6) * 62'(px_s6);
	assign sqz_c = 60'(pz_s6) * 60'(pz_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s7 <= sqx_c[60:0];
			sqz_s7 <= sqz_c[58:0];
			py_s7  <= py_s6;
		end
	end

	// stage 8: sum of squares
	logic valid_s8;
	logic [QW-1:0] sum_s8;
	logic signed [PYW-1:0] py_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s8 <= QW'(sqx_s7) + QW'(sqz_s7);
			py_s8  <= py_s7;
		end
	end

	// square-root cell row
	localparam int QSTEPS = (QW + 1) / 2;
	logic qv [0:QSTEPS];
	logic [QW-1:0] qrem [0:QSTEPS];
	logic [QW-1:0] qres [0:QSTEPS];
	logic [PYW-1:0] qside [0:QSTEPS];

	assign qv[0] = valid_s8;
	assign qrem[0] = sum_s8;
	assign qres[0] = '0;
	assign qside[0] = py_s8;

	generate
		for (genvar j = 0; j < QSTEPS; j++) begin : g_sqrt
			wyr_isqrt_cell #(.VW(QW), .K(QSTEPS - 1 - j), .SW(PYW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_valid(qv[j]), .in_v(qrem[j]), .in_res(qres[j]), .in_side(qside[j]),
				.out_valid(qv[j+1]), .out_v(qrem[j+1]), .out_res(qres[j+1]),
				.out_side(qside[j+1])
			);
		end
	endgenerate

	// arctangent cell row
	logic [31:0] r_c;
	logic signed [PYW-1:0] pyq_c;
	logic vv [0:N];
	logic signed [VXW-1:0] vx [0:N];
	logic signed [VXW-1:0] vy [0:N];
	logic signed [ZW-1:0] vzz [0:N];
	logic vside [0:N];

	assign r_c = qres[QSTEPS][31:0];
	assign pyq_c = qside[QSTEPS];
	assign vv[0] = qv[QSTEPS];
	assign vx[0] = {4'b0000, r_c};
	assign vy[0] = VXW'(pyq_c);
	assign vzz[0] = '0;
	assign vside[0] = (r_c == 32'd0) && (pyq_c == '0);

	generate
		for (genvar i = 0; i < N; i++) begin : g_vec
			localparam logic [32:0] T = {1'b0, wyr_pkg::atan_turn32(i)} + (33'd1 << (SH_TAB - 1));
			localparam int STEP = int'(T >> SH_TAB);
			wyr_cordic_cell #(
				.XW(VXW), .ZW(ZW), .SW(1), .SHIFT(i), .STEP(STEP), .VECTOR(1'b1)
			) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.in_valid(vv[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vzz[i]),
				.in_side(vside[i]),
				.out_valid(vv[i+1]), .out_x(vx[i+1]), .out_y(vy[i+1]), .out_z(vzz[i+1]),
				.out_side(vside[i+1])
			);
		end
	endgenerate

	// stage 9: roll angle
	logic signed [63:0] roll0_c, rs_c;
	logic signed [15:0] roll_c;
	logic valid_s9;
	logic signed [15:0] roll_s9;

	assign roll0_c = -64'(vzz[N]);

	generate
		if (AW >= 16) begin : g_rdn
			assign rs_c = rnd(roll0_c, AW - 16);
		end else begin : g_rup
			assign rs_c = roll0_c <<< (16 - AW);
		end
	endgenerate

	always_comb begin
		if (vside[N]) begin
			roll_c = '0;
		end else if (rs_c > 64'sd16384) begin
			roll_c = 16'sd16384;
		end else if (rs_c < -64'sd16384) begin
			roll_c = -16'sd16384;
		end else begin
			roll_c = rs_c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= vv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s9 <= roll_c;
		end
	end

	// stage 10: deadband
	logic signed [16:0] rl_c, db_c, ex_c;
	logic valid_s10;
	logic [14:0] emag_s10;
	logic eneg_s10;
	logic signed [15:0] roll_s10;

	assign rl_c = 17'(roll_s9);
	assign db_c = $signed({2'b00, deadband_q});

	always_comb begin
		if (rl_c > db_c) begin
			ex_c = rl_c - db_c;
		end else if (rl_c < -db_c) begin
			ex_c = rl_c + db_c;
		end else begin
			ex_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (en) begin
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			emag_s10 <= ex_c[16] ? 15'(-ex_c) : ex_c[14:0];
			eneg_s10 <= ex_c[16];
			roll_s10 <= roll_s9;
		end
	end

	// stage 11: gain
	logic valid_s11;
	logic [30:0] p1_s11;
	logic eneg_s11;
	logic signed [15:0] roll_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (en) begin
			valid_s11 <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s11   <= {16'b0, emag_s10} * {15'b0, gain_q};
			eneg_s11 <= eneg_s10;
			roll_s11 <= roll_s10;
		end
	end

	// stage 12: scale by pi into radian units
	logic valid_s12;
	logic [61:0] p2_s12;
	logic eneg_s12;
	logic signed [15:0] roll_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (en) begin
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s12   <= {31'b0, p1_s11} * {31'b0, wyr_pkg::PI_Q29};
			eneg_s12 <= eneg_s11;
			roll_s12 <= roll_s11;
		end
	end

	// output register: round, clamp, restore sign
	logic [62:0] rnd_c;
	logic [22:0] mag_c;
	logic [14:0] lim_c;
	logic signed [15:0] yaw_c;

	assign rnd_c = {1'b0, p2_s12} + (63'd1 << 39);
	assign mag_c = rnd_c[62:40];
	assign lim_c = (mag_c > {8'b0, limit_q}) ? limit_q : mag_c[14:0];
	assign yaw_c = eneg_s12 ? -$signed({1'b0, lim_c}) : $signed({1'b0, lim_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.yaw_rate   <= yaw_c;
			out_data.roll_angle <= roll_s12;
		end
	end
endmodule
`default_nettype wire

@@ design/wyr_checker.sv @@
// Port-level checks of the weathervane yaw-rate block and their binding
`default_nettype none
`include "weathervane_yaw_rate_macros.svh"
module wyr_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input wyr_pkg::out_beat_t out_data
);
	logic signed [15:0] roll_w;
	logic signed [15:0] yaw_w;
	assign roll_w = out_data.roll_angle;
	assign yaw_w = out_data.yaw_rate;

	`WYR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled beat changed")
	`WYR_ASSERT_IMPL(a_backpressure, 1'b1, in_stall == (out_valid && out_stall), "input stall mismatch")
	`WYR_ASSERT_IMPL(a_roll_range, out_valid, roll_w <= 16'sd16384 && roll_w >= -16'sd16384, "roll range")
	`WYR_ASSERT_IMPL(a_level_no_yaw, out_valid && roll_w == 16'sd0, yaw_w == 16'sd0, "yaw at level roll")
endmodule

bind weathervane_yaw_rate wyr_port_checks u_wyr_port_checks (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
`default_nettype wire
